[rtl/les_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_pkg
// Shared widths, reset values, register indexes and pipeline types for the
// Langmuir equilibrium split unit.
// ----------------------------------------------------------------------------
package les_pkg;

  // Field widths, all unsigned fixed point: amounts and results in Q.16.
  localparam int AmtW       = 24;              // input amounts and registers
  localparam int SumW       = AmtW + 1;        // total amount and results
  localparam int SqW        = 2 * SumW;        // square of the linear coefficient
  localparam int MkW        = SumW + AmtW;     // total times half saturation
  localparam int DiscW      = 52;              // discriminant, Q.32
  localparam int RootW      = DiscW / 2;       // square root of the discriminant
  localparam int RemW       = RootW + 1;       // square root partial remainder
  localparam int SqrtStages = RootW;           // one root bit per stage

  // Configuration register file.
  localparam int CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHalfSat = 1'b0,
    CfgMaxCap  = 1'b1
  } les_cfg_idx_e;

  localparam logic [AmtW-1:0] HalfSatReset = 24'h01_0000;  // 1.0
  localparam logic [AmtW-1:0] MaxCapReset  = 24'h01_0000;  // 1.0

  // Side information that travels with each request down the pipeline.
  typedef struct packed {
    logic [SumW-1:0] m;      // total amount
    logic [SumW-1:0] b_mag;  // magnitude of the linear coefficient
    logic            b_neg;  // linear coefficient is negative
  } les_side_t;

endpackage

[rtl/langmuir_equilibrium_split_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// langmuir_equilibrium_split_unit
// Fully pipelined fixed-point solver that splits a total amount into its
// sorbed and dissolved parts at Langmuir equilibrium.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising clock edge where start is high and busy is
//   low. busy is tied low: the pipeline never stalls, so a new request may be
//   issued on every clock cycle. Each request carries the present sorbed and
//   dissolved amounts in unsigned Q8.16.
//   Its result shows up on equil_sorbed_o and equil_dissolved_o for exactly
//   one cycle, marked by done_o. Results leave in request order. The path
//   holds 32 register stages: the sum, coefficient, products and discriminant
//   add, a 26-stage square root (one root bit per stage), the root adjustment
//   and the output split. The first of them loads on the accepting edge.
//   Throughput is one request per cycle.
//   The receiver cannot hold results off; it must take each one on its strobe.
//   The two configuration registers (half saturation and maximum capacity)
//   are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while no request
//   is in flight. Reset clears all valid bits, so no stray done_o appears,
//   and loads both registers with 1.0.
// ----------------------------------------------------------------------------
module langmuir_equilibrium_split_unit
  import les_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // Request channel
  input  logic            start,
  output logic            busy,
  input  logic [AmtW-1:0] amount_sorbed_i,
  input  logic [AmtW-1:0] amount_dissolved_i,
  // Result channel
  output logic            done_o,
  output logic [SumW-1:0] equil_sorbed_o,
  output logic [SumW-1:0] equil_dissolved_o,
  // Configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [AmtW-1:0]    cfg_wdata_i
);

  // --------------------------------------------------------------------------
  // Configuration registers. Users must change them only while the pipeline
  // is empty; the block does not enforce it. Stages 2 and 3 read them directly.
  // --------------------------------------------------------------------------
  logic [AmtW-1:0] half_sat_q;
  logic [AmtW-1:0] max_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_sat_q <= HalfSatReset;
      max_cap_q  <= MaxCapReset;
    end else if (cfg_we_i) begin
      case (les_cfg_idx_e'(cfg_idx_i))
        CfgHalfSat: half_sat_q <= cfg_wdata_i;
        CfgMaxCap:  max_cap_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline has no back pressure, so requests are always welcome.
  logic req_accept;

  assign busy       = 1'b0;
  assign req_accept = start && !busy;

  // --------------------------------------------------------------------------
  // Stage 1: total amount M = A + B.
  // --------------------------------------------------------------------------
  logic            s1_vld_q;
  logic [SumW-1:0] s1_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= req_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      s1_m_q <= SumW'(amount_sorbed_i) + SumW'(amount_dissolved_i);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: linear coefficient b = capacity + K - M, kept as sign and
  // magnitude so the rest of the datapath stays unsigned.
  // --------------------------------------------------------------------------
  logic            s2_vld_q;
  les_side_t       s2_side_q;
  les_side_t       s2_side_d;
  logic [SumW-1:0] coef_pos;

  always_comb begin
    coef_pos        = SumW'(half_sat_q) + SumW'(max_cap_q);
    s2_side_d.m     = s1_m_q;
    s2_side_d.b_neg = s1_m_q > coef_pos;
    s2_side_d.b_mag = s2_side_d.b_neg ? (s1_m_q - coef_pos) : (coef_pos - s1_m_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_side_q <= s2_side_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: the two products, b^2 and M*K, each on its own multiplier.
  // --------------------------------------------------------------------------
  logic           s3_vld_q;
  les_side_t      s3_side_q;
  logic [SqW-1:0] s3_sq_q;
  logic [MkW-1:0] s3_mk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      s3_side_q <= s2_side_q;
      s3_sq_q   <= SqW'(s2_side_q.b_mag) * SqW'(s2_side_q.b_mag);
      s3_mk_q   <= MkW'(s2_side_q.m) * MkW'(half_sat_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: discriminant b^2 + 4*M*K in Q.32. Its bound stays below 2^52.
  // --------------------------------------------------------------------------
  logic             s4_vld_q;
  les_side_t        s4_side_q;
  logic [DiscW-1:0] s4_disc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_vld_q) begin
      s4_side_q <= s3_side_q;
      s4_disc_q <= DiscW'(s3_sq_q) + DiscW'({s3_mk_q, 2'b00});
    end
  end

  // --------------------------------------------------------------------------
  // Square root pipeline. Each stage brings down the next two discriminant
  // bits, tries to subtract 4q+1 from the remainder and produces one root bit.
  // The remainder never exceeds twice the partial root, so RemW bits hold it.
  // --------------------------------------------------------------------------
  logic                          sq_vld_q  [SqrtStages];
  les_side_t                     sq_side_q [SqrtStages];
  logic [RemW-1:0]               sq_rem_q  [SqrtStages];
  logic [RootW-1:0]              sq_root_q [SqrtStages];
  logic [DiscW-1:0]              sq_disc_q [SqrtStages-1];

  for (genvar gi = 0; gi < SqrtStages; gi++) begin : g_sqrt
    logic             vld_in;
    les_side_t        side_in;
    logic [DiscW-1:0] disc_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [RemW+1:0]  trial;
    logic [RemW+1:0]  test;
    logic [RemW+1:0]  diff;
    logic             fits;

    if (gi == 0) begin : g_first
      assign vld_in  = s4_vld_q;
      assign side_in = s4_side_q;
      assign disc_in = s4_disc_q;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign vld_in  = sq_vld_q[gi-1];
      assign side_in = sq_side_q[gi-1];
      assign disc_in = sq_disc_q[gi-1];
      assign rem_in  = sq_rem_q[gi-1];
      assign root_in = sq_root_q[gi-1];
    end

    assign trial = {rem_in, disc_in[DiscW-1 -: 2]};
    assign test  = {1'b0, root_in, 2'b01};
    assign fits  = trial >= test;
    assign diff  = trial - test;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[gi] <= 1'b0;
      end else begin
        sq_vld_q[gi] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (vld_in) begin
        sq_side_q[gi] <= side_in;
        sq_rem_q[gi]  <= fits ? diff[RemW-1:0] : trial[RemW-1:0];
        sq_root_q[gi] <= {root_in[RootW-2:0], fits};
      end
    end

    // The last stage has no further bits to consume.
    if (gi < SqrtStages - 1) begin : g_disc
      always_ff @(posedge clk_i) begin
        if (vld_in) begin
          sq_disc_q[gi] <= {disc_in[DiscW-3:0], 2'b00};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Root stage: B = (sqrt - b) / 2 rounded toward zero, never below zero.
  // --------------------------------------------------------------------------
  localparam int Last = SqrtStages - 1;

  logic             rt_vld_q;
  logic [SumW-1:0]  rt_m_q;
  logic [RootW-1:0] rt_raw_q;
  logic [RootW-1:0] rt_raw_d;
  logic [RootW:0]   rt_sum;
  logic [RootW-1:0] rt_diff;

  always_comb begin
    rt_sum  = (RootW + 1)'(sq_root_q[Last]) + (RootW + 1)'(sq_side_q[Last].b_mag);
    rt_diff = sq_root_q[Last] - RootW'(sq_side_q[Last].b_mag);
    if (sq_side_q[Last].b_neg) begin
      rt_raw_d = rt_sum[RootW:1];
    end else if (sq_root_q[Last] >= RootW'(sq_side_q[Last].b_mag)) begin
      rt_raw_d = {1'b0, rt_diff[RootW-1:1]};
    end else begin
      rt_raw_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_vld_q <= 1'b0;
    end else begin
      rt_vld_q <= sq_vld_q[Last];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_vld_q[Last]) begin
      rt_m_q   <= sq_side_q[Last].m;
      rt_raw_q <= rt_raw_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: clamp the root to M and split off the sorbed part.
  // --------------------------------------------------------------------------
  logic            done_q;
  logic [SumW-1:0] sorbed_q;
  logic [SumW-1:0] dissolved_q;
  logic [SumW-1:0] root_clamped;

  assign root_clamped = (rt_raw_q > RootW'(rt_m_q)) ? rt_m_q : rt_raw_q[SumW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= rt_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rt_vld_q) begin
      sorbed_q    <= rt_m_q - root_clamped;
      dissolved_q <= root_clamped;
    end
  end

  assign done_o            = done_q;
  assign equil_sorbed_o    = sorbed_q;
  assign equil_dissolved_o = dissolved_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // A result strobe is always the root stage's request from the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(rt_vld_q))
    else $error("done_o does not follow the root stage valid bit");

  // The two parts add back up to a total that two 24-bit amounts can reach.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((SumW + 1)'(equil_sorbed_o) + (SumW + 1)'(equil_dissolved_o)
                <= (SumW + 1)'(33554430)))
    else $error("equilibrium split exceeds the largest possible total");

  // The square root remainder stays within twice the root it belongs to.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld_q[Last] |-> (sq_rem_q[Last] <= {sq_root_q[Last], 1'b0}))
    else $error("square root remainder out of range");
`endif

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Langmuir equilibrium split unit testbench
// Sends requests of sorbed and dissolved amounts under several register
// settings and checks every result against a built-in fixed-point solver.
// A short directed part covers the extremes and the zero cases. Three random
// phases follow, each with its own sender idle rate.
// ----------------------------------------------------------------------------
module testbench;
  import les_pkg::*;

  localparam int PipeLatency = 31;
  // The slowest correct run is about 425 requests. At the highest idle rate
  // the sender is idle a little more often than it sends, and a few pipeline
  // drains come on top. The limit is many times the length of such a run.
  localparam int CycleLimit  = 100000;
  localparam int ReportMax   = 10;

  // One equilibrium split as the unit reports it.
  typedef struct packed {
    logic [SumW-1:0] sorbed;
    logic [SumW-1:0] dissolved;
  } split_t;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  logic [AmtW-1:0] amount_sorbed_i;
  logic [AmtW-1:0] amount_dissolved_i;
  logic            done_o;
  logic [SumW-1:0] equil_sorbed_o;
  logic [SumW-1:0] equil_dissolved_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [AmtW-1:0]    cfg_wdata_i;

  // Our own copy of the two registers. It follows every write that the
  // unit sees, so each prediction uses the setting that was live when the
  // request was taken.
  logic [AmtW-1:0] half_sat_q;
  logic [AmtW-1:0] max_cap_q;

  // Splits that were predicted but have not come out of the unit yet,
  // oldest first.
  split_t pending_splits[$];

  int mismatch_count;
  int cycle_count;

  langmuir_equilibrium_split_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .amount_sorbed_i   (amount_sorbed_i),
    .amount_dissolved_i(amount_dissolved_i),
    .done_o            (done_o),
    .equil_sorbed_o    (equil_sorbed_o),
    .equil_dissolved_o (equil_dissolved_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Floor integer square root, found one bit at a time from the top. The
  // discriminant stays below 2^52, so the root fits in RootW bits. Every
  // trial square stays below 2^52, so nothing overflows 64 bits.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int i = RootW - 1; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= x) r = trial;
    end
    return r;
  endfunction

  // Positive root of B^2 + (cap + K - M) B - M K = 0, in Q.16. The root is
  // found from the exact Q.32 discriminant and is capped at the total M, so
  // the sorbed part can never go negative.
  function automatic split_t solve_split(input logic [AmtW-1:0] sorbed,
                                         input logic [AmtW-1:0] dissolved);
    logic [63:0] total;
    logic [63:0] coef_pos;
    logic [63:0] coef_mag;
    logic        coef_neg;
    logic [63:0] disc;
    logic [63:0] sq;
    logic [63:0] root;
    split_t      res;
    total    = 64'(sorbed) + 64'(dissolved);
    coef_pos = 64'(max_cap_q) + 64'(half_sat_q);
    coef_neg = total > coef_pos;
    coef_mag = coef_neg ? total - coef_pos : coef_pos - total;
    disc     = coef_mag * coef_mag + 64'd4 * total * 64'(half_sat_q);
    sq       = floor_sqrt(disc);
    if (coef_neg) begin
      root = (sq + coef_mag) >> 1;
    end else begin
      root = (sq >= coef_mag) ? (sq - coef_mag) >> 1 : 64'd0;
    end
    if (root > total) root = total;
    res.sorbed    = SumW'(total - root);
    res.dissolved = SumW'(root);
    return res;
  endfunction

  task automatic note_failure(input string msg);
    if (mismatch_count < ReportMax) $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // The checker runs once per rising edge. It compares the result on the
  // outputs first. Then it predicts the request taken at this edge, and only
  // after that does it apply a register write. All of them read values that
  // were driven at the previous falling edge, so the order of events inside
  // the edge does not matter.
  always @(posedge clk_i) begin
    split_t exp_split;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_splits.size() == 0) begin
          note_failure($sformatf("result with no request waiting: sorbed %h dissolved %h",
                                 equil_sorbed_o, equil_dissolved_o));
        end else begin
          exp_split = pending_splits.pop_front();
          if (equil_sorbed_o !== exp_split.sorbed) begin
            note_failure($sformatf("equil_sorbed: expected %h, got %h",
                                   exp_split.sorbed, equil_sorbed_o));
          end
          if (equil_dissolved_o !== exp_split.dissolved) begin
            note_failure($sformatf("equil_dissolved: expected %h, got %h",
                                   exp_split.dissolved, equil_dissolved_o));
          end
        end
      end
      if (start && !busy) begin
        pending_splits.push_back(solve_split(amount_sorbed_i, amount_dissolved_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgHalfSat: half_sat_q = cfg_wdata_i;
          CfgMaxCap:  max_cap_q  = cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // A run that hangs is cut off here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Puts one request on the ports at a falling edge. It returns after the
  // rising edge that takes the request. start stays high, so a request that
  // follows at once goes out without a gap.
  task automatic send_request(input logic [AmtW-1:0] sorbed,
                              input logic [AmtW-1:0] dissolved);
    @(negedge clk_i);
    start              <= 1'b1;
    amount_sorbed_i    <= sorbed;
    amount_dissolved_i <= dissolved;
    do @(posedge clk_i); while (busy);
  endtask

  // Holds the request line low for a number of cycles.
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Lowers start, then waits until every predicted split has come out.
  task automatic drain_pipeline();
    hold_off(1);
    while (pending_splits.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Register writes happen only while the pipeline is empty.
  task automatic write_reg(input les_cfg_idx_e idx, input logic [AmtW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_constants(input logic [AmtW-1:0] half_sat,
                               input logic [AmtW-1:0] max_cap);
    write_reg(CfgHalfSat, half_sat);
    write_reg(CfgMaxCap, max_cap);
  endtask

  // A register value for the random phases. It is one of the extremes about
  // two times in five, and otherwise small or spread over the whole range.
  function automatic logic [AmtW-1:0] pick_reg_value();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return AmtW'($urandom_range(0, 'h2_0000));
      default: return AmtW'($urandom);
    endcase
  endfunction

  // An input amount for the random phases. Small amounts keep the total
  // near the registers, where the root moves most. Full-range amounts make
  // every bit take both values.
  function automatic logic [AmtW-1:0] pick_amount();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return AmtW'($urandom_range(0, 'h4_0000));
      default: return AmtW'($urandom);
    endcase
  endfunction

  // With the reset values K = 1.0 and capacity = 1.0: a zero total, the
  // largest inputs, one side empty, a total that sits right at cap + K and
  // the smallest nonzero total.
  task automatic test_reset_constants();
    send_request('0, '0);
    send_request('1, '1);
    send_request('1, '0);
    send_request('0, '1);
    send_request(24'h01_0000, 24'h01_0000);
    send_request(24'h00_0001, 24'h00_0000);
    drain_pipeline();
  endtask

  // Zero half saturation. The root is M - cap when M is above the capacity
  // and 0 otherwise. With the capacity at zero as well, the whole total
  // ends up dissolved.
  task automatic test_zero_half_sat();
    set_constants('0, 24'h01_0000);
    send_request('0, '0);
    send_request(24'h00_8000, '0);
    send_request(24'h01_0000, 24'h01_0000);
    send_request('1, '1);
    drain_pipeline();
    set_constants('0, '0);
    send_request('0, '0);
    send_request(24'h00_0001, 24'h00_0001);
    send_request('1, '1);
    drain_pipeline();
  endtask

  // Both registers at full scale, then a full-scale K with no capacity.
  // These give the largest discriminant and the largest linear coefficient.
  task automatic test_register_extremes();
    set_constants('1, '1);
    send_request('0, '0);
    send_request('1, '1);
    send_request(24'h00_0001, '0);
    drain_pipeline();
    set_constants('1, '0);
    send_request('1, '1);
    send_request(24'h12_3456, '0);
    send_request('0, 24'hAB_CDEF);
    drain_pipeline();
  endtask

  // Random requests with the sender idle in about idle_pct cycles of a
  // hundred: after each request, every further cycle is left idle with that
  // chance. Halfway through, the sender waits for the pipeline to empty and
  // loads new constants.
  task automatic test_random_phase(input int count, input int idle_pct);
    set_constants(pick_reg_value(), pick_reg_value());
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        drain_pipeline();
        set_constants(pick_reg_value(), pick_reg_value());
      end
      send_request(pick_amount(), pick_amount());
      while ($urandom_range(0, 99) < idle_pct) hold_off(1);
    end
    drain_pipeline();
  endtask

  initial begin
    mismatch_count     = 0;
    cycle_count        = 0;
    half_sat_q         = HalfSatReset;
    max_cap_q          = MaxCapReset;
    rst_ni             = 1'b0;
    start              = 1'b0;
    amount_sorbed_i    = '0;
    amount_dissolved_i = '0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CfgHalfSat;
    cfg_wdata_i        = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_constants();
    test_zero_half_sat();
    test_register_extremes();
    test_random_phase(135, 24);
    test_random_phase(135, 57);
    test_random_phase(135, 0);

    // Let a result that nobody asked for show up before the verdict.
    repeat (PipeLatency + 8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_splits.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/les_pkg.sv
rtl/langmuir_equilibrium_split_unit.sv
dv/testbench.sv
